// ----- hdl/text_glyph_framebuffer_defines.svh -----
// Assertion macros shared by the frame store RTL.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef TEXT_GLYPH_FRAMEBUFFER_DEFINES_SVH
`define TEXT_GLYPH_FRAMEBUFFER_DEFINES_SVH

// Same-cycle implication.
`define TGFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TGFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tgfb_pkg.sv -----
// Package for the text glyph frame store: word types, request codes,
// controller/datapath interface structs and the 5x7 font table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgfb_pkg;

	localparam int DEF_COLUMNS = 128;
	localparam int DEF_PAGES   = 8;
	localparam int WIDE_AW     = 14;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_COUNT = 38;
	localparam logic [5:0] GLYPH_DIGIT_BASE = 6'd27;
	localparam logic [5:0] GLYPH_COLON      = 6'd37;

	typedef enum logic [1:0] {
		REQ_CHAR   = 2'd0,
		REQ_CURSOR = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_READ   = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [7:0] cursor_column;
		logic [7:0] cursor_pixel_row;
		logic [9:0] read_address;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] column_now;
		logic [4:0] page_now;
	} out_word_t;

	typedef struct packed {
		logic       accept;
		logic       draw_we;
		logic       draw_last;
		logic [2:0] draw_idx;
		logic       clr_we;
		logic       read_en;
		logic       load_out;
	} tgfb_cmd_t;

	typedef struct packed {
		req_type_t req_type;
		logic      clr_last;
		logic      out_free;
	} tgfb_status_t;

	localparam logic [7:0] GLYPHS [GLYPH_COUNT][GLYPH_COLS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
		'{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
		'{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
		'{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
		'{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
		'{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
		'{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
		'{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
		'{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
		'{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}
	};

	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [5:0] idx;
		idx = '0;
		if (code >= 8'h41 && code <= 8'h5A) begin
			idx = 6'(code - 8'h41) + 6'd1;
		end else if (code >= 8'h30 && code <= 8'h39) begin
			idx = 6'(code - 8'h30) + GLYPH_DIGIT_BASE;
		end else if (code == 8'h3A) begin
			idx = GLYPH_COLON;
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tgfb_ctrl.sv -----
// Controller state machine for the text glyph frame store.
// Depends on tgfb_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
`default_nettype none

module tgfb_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_stall,
	input  wire tgfb_pkg::tgfb_status_t status,
	output tgfb_pkg::tgfb_cmd_t         cmd
);
	import tgfb_pkg::*;

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DRAW  = 6'b000100,
		S_CLEAR = 6'b001000,
		S_READ  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] cnt_q;
	logic       accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.accept    = accept;
		cmd.draw_idx  = cnt_q;
		cmd.draw_last = (cnt_q == 3'(GLYPH_COLS - 1));
		unique case (state_q)
			S_INIT: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (status.req_type)
						REQ_CHAR:   state_d = S_DRAW;
						REQ_CURSOR: state_d = S_DONE;
						REQ_CLEAR:  state_d = S_CLEAR;
						REQ_READ:   state_d = S_READ;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_DRAW: begin
				cmd.draw_we = 1'b1;
				if (cmd.draw_last) begin
					state_d = S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.read_en = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.draw_we) begin
				cnt_q <= cmd.draw_last ? 3'd0 : cnt_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tgfb_dp.sv -----
// Datapath for the text glyph frame store: frame memory, cursors,
// clear address counter and output register. Depends on tgfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgfb_dp #(
	parameter int COLUMNS = tgfb_pkg::DEF_COLUMNS,
	parameter int PAGES   = tgfb_pkg::DEF_PAGES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire tgfb_pkg::in_word_t      req,
	input  wire                          rsp_stall,
	output logic                         rsp_valid,
	output tgfb_pkg::out_word_t          rsp,
	input  wire tgfb_pkg::tgfb_cmd_t     cmd,
	output tgfb_pkg::tgfb_status_t       status
);
	import tgfb_pkg::*;

	localparam int DEPTH  = COLUMNS * PAGES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_q;
	logic [7:0]        col_q;
	logic [4:0]        page_q;
	req_type_t         req_q;
	logic [5:0]        glyph_q;
	logic [ADDR_W-1:0] raddr_q;
	logic              raddr_ok_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              rsp_valid_q;
	out_word_t         rsp_q;

	logic [WIDE_AW-1:0] draw_addr_w;
	logic [WIDE_AW-1:0] req_addr_w;
	logic               draw_ok;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [7:0]         wdata;

	assign draw_addr_w = WIDE_AW'(page_q) * WIDE_AW'(COLUMNS) + WIDE_AW'(col_q);
	assign req_addr_w  = WIDE_AW'(req.read_address);
	assign draw_ok     = ({1'b0, col_q} < 9'(COLUMNS)) && ({1'b0, page_q} < 6'(PAGES));
	assign we          = (cmd.draw_we && draw_ok) || cmd.clr_we;
	assign waddr       = cmd.clr_we ? clr_addr_q : draw_addr_w[ADDR_W-1:0];
	assign wdata       = cmd.clr_we ? 8'h00 : GLYPHS[glyph_q][cmd.draw_idx];

	assign status.req_type = req_type_t'(req.req_type);
	assign status.clr_last = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign status.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.read_en) begin
			rd_q <= mem[raddr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= req_type_t'(req.req_type);
			glyph_q    <= glyph_index(req.char_code);
			raddr_q    <= req_addr_w[ADDR_W-1:0];
			raddr_ok_q <= (req_addr_w < WIDE_AW'(DEPTH));
		end
		if (cmd.load_out) begin
			rsp_q.read_data  <= (req_q == REQ_READ && raddr_ok_q) ? rd_q : 8'h00;
			rsp_q.column_now <= col_q;
			rsp_q.page_now   <= page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			page_q      <= '0;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && req.req_type == REQ_CURSOR) begin
				col_q  <= req.cursor_column;
				page_q <= req.cursor_pixel_row[7:3];
			end else if (cmd.draw_we) begin
				col_q <= col_q + (cmd.draw_last ? 8'd2 : 8'd1);
			end
			if (cmd.clr_we) begin
				clr_addr_q <= status.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/text_glyph_framebuffer.sv -----
// Text glyph frame store, top level: controller plus datapath. Uses tgfb_pkg.
// A character word makes 5 column writes on the single-port frame memory before
// its result loads; a clear writes all COLUMNS*PAGES addresses once.
// One word is in flight at a time; the next is taken in the cycle after the result loads.
// After reset a clearing pass over all COLUMNS*PAGES addresses (1024 by default)
// zeroes the memory while input stays stalled; cursors reset to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "text_glyph_framebuffer_defines.svh"

module text_glyph_framebuffer #(
	parameter int COLUMNS = tgfb_pkg::DEF_COLUMNS,
	parameter int PAGES   = tgfb_pkg::DEF_PAGES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire tgfb_pkg::in_word_t      req,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output tgfb_pkg::out_word_t          rsp
);
	import tgfb_pkg::*;

	tgfb_cmd_t    cmd;
	tgfb_status_t status;

	tgfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tgfb_dp #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.status    (status)
	);

	`TGFB_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "word accepted back to back")
	`TGFB_ASSERT_NOW(a_single_mem_op, 1'b1, $onehot0({cmd.draw_we, cmd.clr_we, cmd.read_en}), "frame memory port used twice")
	`TGFB_ASSERT_NOW(a_load_when_free, cmd.load_out, !rsp_valid || !rsp_stall, "result overwritten while stalled")

endmodule

`default_nettype wire
